// ===== rtl/jrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package jrc_pkg;

  localparam int AXIS_W = 16;
  localparam int BTN_W  = 16;
  localparam int NAX    = 4;

  localparam logic signed [16:0] AXIS_HI = 17'sd32767;
  localparam logic signed [16:0] AXIS_LO = -17'sd32768;
  localparam logic [14:0] DEAD_ZONE_RST = 15'd1000;
  localparam logic [2:0]  AXES_RST      = 3'd4;
  localparam logic [47:0] CALIB_RST     = 48'h8000_0000_7FFF;

  localparam logic [2:0] REG_DEAD_ZONE = 3'd0;
  localparam logic [2:0] REG_AXES      = 3'd1;
  localparam logic [2:0] REG_CALIB0    = 3'd2;
  localparam logic [2:0] REG_CALIB3    = 3'd5;

  localparam logic EV_BUTTON = 1'b0;
  localparam logic EV_AXIS   = 1'b1;

  typedef struct packed {
    logic [15:0]        buttons;
    logic signed [15:0] axis_0;
    logic signed [15:0] axis_1;
    logic signed [15:0] axis_2;
    logic signed [15:0] axis_3;
  } in_word_t;

  typedef struct packed {
    logic               event_kind;
    logic [3:0]         button_index;
    logic               button_pressed;
    logic [15:0]        button_mask;
    logic signed [15:0] axis_out_0;
    logic signed [15:0] axis_out_1;
    logic signed [15:0] axis_out_2;
    logic signed [15:0] axis_out_3;
    logic [2:0]         valid_axes;
    logic               last_of_run;
  } out_word_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [15:0]        cur;
    logic [15:0]        changed;
    logic signed [15:0] axis_0;
    logic signed [15:0] axis_1;
    logic signed [15:0] axis_2;
    logic signed [15:0] axis_3;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/jrc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module jrc_front #(
  parameter int BUTTONS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  jrc_pkg::in_word_t  in_data,
  output logic               job_valid,
  input  wire                job_ready,
  output jrc_pkg::job_t      job
);
  import jrc_pkg::*;

  localparam int NB = (BUTTONS > 16) ? 16 : BUTTONS;
  localparam logic [15:0] BMASK = (NB >= 16) ? 16'hFFFF : 16'((32'd1 << NB) - 32'd1);

  // two-entry queue
  job_t        q_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wp_r, rp_r;
  logic [15:0] prev_r;
  logic [15:0] cur;
  logic        push, pop;

  assign cur      = in_data.buttons & BMASK;
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = job_valid && job_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job      = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      prev_r <= 16'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r   <= !wp_r;
        prev_r <= cur;
      end
      if (pop) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].cur     <= cur;
      q_r[wp_r].changed <= (cur ^ prev_r) & BMASK;
      q_r[wp_r].axis_0  <= in_data.axis_0;
      q_r[wp_r].axis_1  <= in_data.axis_1;
      q_r[wp_r].axis_2  <= in_data.axis_2;
      q_r[wp_r].axis_3  <= in_data.axis_3;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/jrc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// signed restoring divider, quotient truncated toward zero, one bit per cycle
module jrc_div (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire signed [32:0]  num,
  input  wire signed [17:0]  den,
  output logic               done,
  output logic signed [32:0] quo
);
  logic [32:0] n_r;
  logic [32:0] q_r;
  logic [17:0] d_r;
  logic [17:0] rem_r;
  logic [5:0]  cnt_r;
  logic        neg_r, busy_r;
  logic [18:0] trial;

  assign trial = {rem_r, n_r[32]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd33;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num[32] ? 33'(-num) : num;
      d_r   <= den[17] ? 18'(-den) : den;
      neg_r <= num[32] ^ den[17];
      rem_r <= 18'd0;
      q_r   <= 33'd0;
    end else if (busy_r) begin
      n_r <= {n_r[31:0], 1'b0};
      if (!trial[18]) begin
        rem_r <= trial[17:0];
        q_r   <= {q_r[31:0], 1'b1};
      end else begin
        rem_r <= {rem_r[16:0], n_r[32]};
        q_r   <= {q_r[31:0], 1'b0};
      end
    end
  end

  assign quo = neg_r ? 33'(-q_r) : q_r;
endmodule
`default_nettype wire

// ===== rtl/jrc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module jrc_back #(
  parameter int AXES = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                job_valid,
  output logic               job_ready,
  input  jrc_pkg::job_t      job,
  input  wire [14:0]         dead_zone,
  input  wire [2:0]          axes_in_use,
  input  wire [191:0]        calib,
  output logic               out_valid,
  input  wire                out_stall,
  output jrc_pkg::out_word_t out_data
);
  import jrc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_BTN, S_AXSET, S_AXWAIT, S_REPORT, S_OUT} st_t;

  st_t                st_r;
  job_t               j_r;
  logic [15:0]        pend_r;
  logic [1:0]         ax_r;
  logic [2:0]         naxes_r;
  logic               moved_r;
  logic               ret_btn_r;
  logic signed [15:0] vals_r [4];
  logic signed [15:0] newv_r [4];
  out_word_t          o_r;

  logic               dstart, ddone;
  logic signed [32:0] dnum, dquo;
  logic signed [17:0] dden;
  logic               zero_span_r;

  logic [3:0]         lo_idx;
  logic               more_btn;
  logic [15:0]        pend_rest;
  logic [47:0]        cal;
  logic signed [15:0] raw, mn, ce, mx;
  logic signed [17:0] span;
  logic signed [16:0] off;
  logic signed [32:0] clamped;
  logic [15:0]        mag;
  logic signed [15:0] fin;
  logic               last_ax;
  out_word_t          btn_w, axw_w;

  jrc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  // lowest pending button
  always_comb begin
    lo_idx = 4'd0;
    for (int i = 15; i >= 0; i--) if (pend_r[i]) lo_idx = 4'(i);
    pend_rest = pend_r & ~(16'd1 << lo_idx);
  end
  assign more_btn = (pend_rest != 16'd0);

  always_comb begin
    case (ax_r)
      2'd0: begin
        raw = j_r.axis_0;
        cal = calib[47:0];
      end
      2'd1: begin
        raw = j_r.axis_1;
        cal = calib[95:48];
      end
      2'd2: begin
        raw = j_r.axis_2;
        cal = calib[143:96];
      end
      default: begin
        raw = j_r.axis_3;
        cal = calib[191:144];
      end
    endcase
    mn = cal[47:32];
    ce = cal[31:16];
    mx = cal[15:0];
    off  = 17'(raw) - 17'(ce);
    span = (raw >= ce) ? (18'(mx) - 18'(ce)) : (18'(ce) - 18'(mn));
    dnum = 33'(off) * 33'sd32767;
    dden = span;
    clamped = (dquo > 33'(AXIS_HI)) ? 33'(AXIS_HI)
            : (dquo < 33'(AXIS_LO)) ? 33'(AXIS_LO) : dquo;
    mag = clamped[15] ? 16'(-clamped[15:0]) : clamped[15:0];
    if (zero_span_r) fin = 16'sd0;
    else if (clamped[15] ? (17'(mag) == 17'd32768 ? 1'b0 : mag < {1'b0, dead_zone})
                         : (mag < {1'b0, dead_zone}))
      fin = 16'sd0;
    else fin = clamped[15:0];
    last_ax = ({1'b0, ax_r} + 3'd1 >= naxes_r);
  end

  // axes are settled before any button word goes out, so the last word is known
  always_comb begin
    btn_w = '0;
    btn_w.event_kind     = EV_BUTTON;
    btn_w.button_index   = lo_idx;
    btn_w.button_pressed = j_r.cur[lo_idx];
    btn_w.button_mask    = j_r.cur;
    btn_w.last_of_run    = !more_btn && !moved_r;
    axw_w = '0;
    axw_w.event_kind  = EV_AXIS;
    axw_w.button_mask = j_r.cur;
    axw_w.axis_out_0  = (naxes_r > 3'd0) ? newv_r[0] : 16'sd0;
    axw_w.axis_out_1  = (naxes_r > 3'd1) ? newv_r[1] : 16'sd0;
    axw_w.axis_out_2  = (naxes_r > 3'd2) ? newv_r[2] : 16'sd0;
    axw_w.axis_out_3  = (naxes_r > 3'd3) ? newv_r[3] : 16'sd0;
    axw_w.valid_axes  = naxes_r;
    axw_w.last_of_run = 1'b1;
  end

  assign dstart    = (st_r == S_AXSET) && (naxes_r != 3'd0) && (span != 18'sd0);
  assign job_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_data  = o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      pend_r  <= 16'd0;
      ax_r    <= 2'd0;
      naxes_r <= 3'd0;
      moved_r <= 1'b0;
      ret_btn_r <= 1'b0;
      zero_span_r <= 1'b0;
      for (int i = 0; i < 4; i++) vals_r[i] <= 16'sd0;
    end else begin
      case (st_r)
        S_IDLE: if (job_valid) begin
          j_r     <= job;
          pend_r  <= job.changed;
          naxes_r <= (axes_in_use > 3'(AXES)) ? 3'(AXES) : axes_in_use;
          ax_r    <= 2'd0;
          moved_r <= 1'b0;
          for (int i = 0; i < 4; i++) newv_r[i] <= vals_r[i];
          st_r <= S_AXSET;
        end
        S_AXSET: begin
          if (naxes_r == 3'd0) st_r <= S_BTN;
          else begin
            zero_span_r <= (span == 18'sd0);
            st_r <= S_AXWAIT;
          end
        end
        S_AXWAIT: if (zero_span_r || ddone) begin
          newv_r[ax_r] <= fin;
          if (fin != vals_r[ax_r]) moved_r <= 1'b1;
          if (last_ax) st_r <= S_BTN;
          else begin
            ax_r <= ax_r + 2'd1;
            st_r <= S_AXSET;
          end
        end
        S_BTN: begin
          if (pend_r != 16'd0) begin
            o_r       <= btn_w;
            pend_r    <= pend_rest;
            ret_btn_r <= 1'b1;
            st_r      <= S_OUT;
          end else st_r <= S_REPORT;
        end
        S_REPORT: begin
          for (int i = 0; i < 4; i++) vals_r[i] <= newv_r[i];
          if (moved_r) begin
            o_r       <= axw_w;
            ret_btn_r <= 1'b0;
            st_r      <= S_OUT;
          end else st_r <= S_IDLE;
        end
        S_OUT: if (!out_stall) st_r <= ret_btn_r ? S_BTN : S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/joystick_report_conditioner.sv =====
// Flow: the report is registered in the queue, taken by the back end, then each axis in use
// passes through the shared one-bit-per-cycle divider (skipped on a zero span), then one word
// goes out per button event and a closing axis report follows when any axis moved.
// Throughput: one report at a time in the back end; a two-word queue lets the front
// take up to two more reports meanwhile.
// Reset (rst_n, synchronous): registers to defaults, stored mask and axis values to zero.
`timescale 1ns / 1ps
`default_nettype none
module joystick_report_conditioner #(
  parameter int AXES    = 4,
  parameter int BUTTONS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  jrc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output jrc_pkg::out_word_t out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [2:0]          cfg_index,
  input  wire [47:0]         cfg_data
);
  import jrc_pkg::*;

  logic [14:0]  dz_r;
  logic [2:0]   ax_r;
  logic [191:0] cal_r;
  logic         jv, jr;
  job_t         jb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r  <= DEAD_ZONE_RST;
      ax_r  <= AXES_RST;
      cal_r <= {4{CALIB_RST}};
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEAD_ZONE) dz_r <= cfg_data[14:0];
      else if (cfg_index == REG_AXES) ax_r <= cfg_data[2:0];
      else if (cfg_index >= REG_CALIB0 && cfg_index <= REG_CALIB3)
        cal_r[{cfg_index[1:0] - 2'd2, 6'd0} - {cfg_index[1:0] - 2'd2, 4'd0} +: 48]
          <= cfg_data;
    end
  end

  jrc_front #(.BUTTONS(BUTTONS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .job_valid(jv), .job_ready(jr), .job(jb)
  );

  jrc_back #(.AXES(AXES)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr), .job(jb),
    .dead_zone(dz_r), .axes_in_use(ax_r), .calib(cal_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
`default_nettype wire

// ===== rtl/jrc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module jrc_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_stall,
  input jrc_pkg::out_word_t out_data
);
  import jrc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
  a_axis_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_BUTTON |->
      out_data.valid_axes == 3'd0 && out_data.axis_out_0 == 16'sd0) else $error("btn fields");
  a_axis_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_AXIS |-> out_data.last_of_run)
    else $error("axis last");
  a_axis_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_AXIS |-> out_data.valid_axes <= 3'd4)
    else $error("axis count");
endmodule

bind joystick_report_conditioner jrc_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
